>>> hdl/tabp_pkg.sv
// ----------------------------------------------------------------------------
// tabp_pkg
// Shared widths, register indexes, queue types and the block mixing
// functions of the toy AES block pipeline.
// ----------------------------------------------------------------------------
package tabp_pkg;

   localparam int KEY_CHARS   = 16;
   localparam int BLOCK_BYTES = 16;
   localparam int BYTE_W      = 8;
   localparam int LETTER_W    = 7;
   localparam int KEY_POS_W   = 4;
   localparam int KEY_LEN_W   = 5;
   localparam int FILL_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int BLOCK_W     = BLOCK_BYTES * BYTE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LEN  = 2'd2;

   localparam logic [BYTE_W-1:0]     ASCII_A        = 8'h41;
   localparam logic [CSR_DATA_W-1:0] KEY_RESET      = 64'h4141_4141_4141_4141;
   localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET  = 5'd1;

   // One closed block on its way from the front end to the back end.
   typedef struct packed {
      logic               eom;
      logic [BLOCK_W-1:0] data;
   } tabp_block_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic not_empty;
   } tabp_qstat_type;

   function automatic logic [BYTE_W-1:0] gf_double(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] d;
      d = {v[BYTE_W-2:0], 1'b0};
      if (v[BYTE_W-1]) begin
         d = d ^ 8'h1B;
      end
      return d;
   endfunction

   function automatic logic [BYTE_W-1:0] parity_mark(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] m;
      m = v;
      if (^v) begin
         m[BYTE_W-1] = 1'b1;
      end
      return m;
   endfunction

   // Row rotation, parity marking and MixColumns over a whole block.
   // Byte i of the block sits in bits 8i+7..8i, row-major.
   function automatic logic [BLOCK_W-1:0] mix_block(input logic [BLOCK_W-1:0] blk);
      logic [BYTE_W-1:0]  s [BLOCK_BYTES];
      logic [BLOCK_W-1:0] m;
      logic [BYTE_W-1:0]  a0, a1, a2, a3;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            s[r*4+c] = parity_mark(blk[(r*4 + ((c + r) % 4))*BYTE_W +: BYTE_W]);
         end
      end
      m = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[c];
         a1 = s[c+4];
         a2 = s[c+8];
         a3 = s[c+12];
         m[c*BYTE_W +: BYTE_W]      = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
         m[(c+4)*BYTE_W +: BYTE_W]  = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
         m[(c+8)*BYTE_W +: BYTE_W]  = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
         m[(c+12)*BYTE_W +: BYTE_W] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
      end
      return m;
   endfunction

endpackage

>>> hdl/tabp_req_if.sv
// ----------------------------------------------------------------------------
// tabp_req_if
// Request channel: one plaintext letter and its end-of-message flag.
// ----------------------------------------------------------------------------
interface tabp_req_if;
   logic                          valid;
   logic                          ready;
   logic [tabp_pkg::LETTER_W-1:0] letter;
   logic                          end_of_message;

   modport source (output valid, output letter, output end_of_message, input ready);
   modport sink   (input valid, input letter, input end_of_message, output ready);
endinterface

>>> hdl/tabp_rsp_if.sv
// ----------------------------------------------------------------------------
// tabp_rsp_if
// Response channel: one cipher byte with its block and message markers.
// ----------------------------------------------------------------------------
interface tabp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tabp_pkg::BYTE_W-1:0] cipher_byte;
   logic                        block_last;
   logic                        message_last;

   modport source (output valid, output cipher_byte, output block_last,
                   output message_last, input ready);
   modport sink   (input valid, input cipher_byte, input block_last,
                   input message_last, output ready);
endinterface

>>> hdl/tabp_front.sv
// ----------------------------------------------------------------------------
// tabp_front
// Takes letters, applies the running key shift mod 26, gathers them into a
// block and pushes each closed, padded block into the queue.
// ----------------------------------------------------------------------------
module tabp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   tabp_req_if.sink                             req,
   input  logic                                 csr_write_enable,
   input  logic [tabp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tabp_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  tabp_pkg::tabp_qstat_type             qstat,
   output logic                                 push,
   output tabp_pkg::tabp_block_type             blk
);
   import tabp_pkg::*;

   logic [CSR_DATA_W-1:0] key_low_ff, key_low_in;
   logic [CSR_DATA_W-1:0] key_high_ff, key_high_in;
   logic [KEY_LEN_W-1:0]  key_len_ff, key_len_in;
   logic [KEY_POS_W-1:0]  key_pos_ff, key_pos_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [BYTE_W-1:0]     store_ff [BLOCK_BYTES];

   logic [2*CSR_DATA_W-1:0] key_all;
   logic [BYTE_W-1:0]       key_byte;
   logic [KEY_LEN_W-1:0]    eff_len;
   logic [KEY_LEN_W-1:0]    pos_plus;
   logic [8:0]              sum;
   logic [13:0]             sum_x39;
   logic [3:0]              quot;
   logic [8:0]              rem_wide;
   logic [5:0]              rem;
   logic [BYTE_W-1:0]       enc;
   logic                    accept;
   logic                    close;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;
   assign close     = req.end_of_message || (fill_ff == FILL_W'(BLOCK_BYTES - 1));
   assign push      = accept && close;

   // Key letter at the current position.
   assign key_all  = {key_high_ff, key_low_ff};
   assign key_byte = key_all[{key_pos_ff, 3'b000} +: BYTE_W];

   // (letter - 'A') + (key - 'A') + 6*26 reduces to letter + key + 26.
   // The remainder uses an under-estimated reciprocal and one correction.
   assign sum      = 9'(req.letter) + 9'(key_byte) + 9'd26;
   assign sum_x39  = 14'(sum) * 14'd39;
   assign quot     = sum_x39[13:10];
   assign rem_wide = sum - 9'(quot) * 9'd26;
   always_comb begin
      if (rem_wide >= 9'd26) begin
         rem = 6'(rem_wide - 9'd26);
      end else begin
         rem = rem_wide[5:0];
      end
   end
   assign enc = ASCII_A + 8'(rem);

   always_comb begin
      eff_len = key_len_ff;
      if (eff_len == '0) begin
         eff_len = KEY_LEN_W'(1);
      end
      if (eff_len > KEY_LEN_W'(KEY_CHARS)) begin
         eff_len = KEY_LEN_W'(KEY_CHARS);
      end
   end
   assign pos_plus = KEY_LEN_W'(key_pos_ff) + KEY_LEN_W'(1);

   always_comb begin
      key_pos_in = key_pos_ff;
      fill_in    = fill_ff;
      if (accept) begin
         if (req.end_of_message || pos_plus >= eff_len) begin
            key_pos_in = '0;
         end else begin
            key_pos_in = pos_plus[KEY_POS_W-1:0];
         end
         if (close) begin
            fill_in = '0;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      key_len_in  = key_len_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_in  = csr_write_data;
            CSR_KEY_HIGH: key_high_in = csr_write_data;
            CSR_KEY_LEN:  key_len_in  = csr_write_data[KEY_LEN_W-1:0];
            default:      key_len_in  = key_len_ff;
         endcase
      end
   end

   // Closed block: earlier letters, this letter, then plain 'A' padding.
   always_comb begin
      blk.eom = req.end_of_message;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (FILL_W'(i) == fill_ff) begin
            blk.data[i*BYTE_W +: BYTE_W] = enc;
         end else if (FILL_W'(i) < fill_ff) begin
            blk.data[i*BYTE_W +: BYTE_W] = store_ff[i];
         end else begin
            blk.data[i*BYTE_W +: BYTE_W] = ASCII_A;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= KEY_RESET;
         key_high_ff <= KEY_RESET;
         key_len_ff  <= KEY_LEN_RESET;
         key_pos_ff  <= '0;
         fill_ff     <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_len_ff  <= key_len_in;
         key_pos_ff  <= key_pos_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[fill_ff] <= enc;
      end
   end

endmodule

>>> hdl/tabp_queue.sv
// ----------------------------------------------------------------------------
// tabp_queue
// Two-entry queue of closed blocks between the front end and the back end.
// ----------------------------------------------------------------------------
module tabp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tabp_pkg::tabp_block_type  push_blk,
   input  logic                      pop,
   output tabp_pkg::tabp_block_type  head_blk,
   output tabp_pkg::tabp_qstat_type  qstat
);
   import tabp_pkg::*;

   tabp_block_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign qstat.full      = (count_ff == 2'd2);
   assign qstat.not_empty = (count_ff != 2'd0);
   assign head_blk        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_blk;
      end
   end

endmodule

>>> hdl/tabp_back.sv
// ----------------------------------------------------------------------------
// tabp_back
// Loads a block from the queue, mixes it into a register and sends its
// sixteen bytes out one per handshake.
// ----------------------------------------------------------------------------
module tabp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tabp_pkg::tabp_block_type  head_blk,
   input  tabp_pkg::tabp_qstat_type  qstat,
   output logic                      pop,
   tabp_rsp_if.source                rsp
);
   import tabp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } tabp_state_type;

   tabp_state_type       state_ff, state_in;
   logic [BLOCK_W-1:0]   mixed_ff, mixed_in;
   logic                 eom_ff, eom_in;
   logic [FILL_W-1:0]    idx_ff, idx_in;
   logic                 take;
   logic                 done;

   assign rsp.valid        = (state_ff == ST_EMIT);
   assign rsp.cipher_byte  = mixed_ff[{idx_ff, 3'b000} +: BYTE_W];
   assign rsp.block_last   = (idx_ff == FILL_W'(BLOCK_BYTES - 1));
   assign rsp.message_last = rsp.block_last && eom_ff;

   assign take = rsp.valid && rsp.ready;
   assign done = take && rsp.block_last;
   assign pop  = qstat.not_empty && ((state_ff == ST_IDLE) || done);

   always_comb begin
      state_in = state_ff;
      mixed_in = mixed_ff;
      eom_in   = eom_ff;
      idx_in   = idx_ff;
      if (pop) begin
         state_in = ST_EMIT;
         mixed_in = mix_block(head_blk.data);
         eom_in   = head_blk.eom;
         idx_in   = '0;
      end else if (done) begin
         state_in = ST_IDLE;
      end else if (take) begin
         idx_in = idx_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mixed_ff <= mixed_in;
      eom_ff   <= eom_in;
   end

endmodule

>>> hdl/toy_aes_block_pipeline_unit.sv
// ----------------------------------------------------------------------------
// toy_aes_block_pipeline_unit
// A request that closes a block (full block or end of message) writes it into
// the queue; the back end mixes it and shows its first cipher byte once free.
// Throughput: one letter per cycle while the block queue has room; the back
// end sends one byte per cycle while the response side is ready.
// Reset (synchronous, active high) restores the default key, empties the
// queue and the partial block; no clearing pass is needed.
// ----------------------------------------------------------------------------
module toy_aes_block_pipeline_unit (
   input  logic                             clock,
   input  logic                             reset,
   tabp_req_if.sink                         req_ch,
   tabp_rsp_if.source                       rsp_ch,
   input  logic                             csr_write_enable,
   input  logic [tabp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tabp_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tabp_pkg::*;

   // The front end shifts each letter by the running key and collects the
   // block. A request that fills the block or ends the message pushes the
   // padded block into the queue in the same cycle, so the front end only
   // stalls when both queue entries are taken.
   tabp_block_type push_blk;
   tabp_block_type head_blk;
   tabp_qstat_type qstat;
   logic           push;
   logic           pop;

   tabp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .qstat            (qstat),
      .push             (push),
      .blk              (push_blk)
   );

   // The queue decouples letter intake from byte output, so a stalled
   // response side does not stop the next block from being gathered.
   tabp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_blk (push_blk),
      .pop      (pop),
      .head_blk (head_blk),
      .qstat    (qstat)
   );

   // The back end mixes a whole block into its output register when it pops
   // it, then walks the sixteen bytes in row-major order. If the queue holds a
   // block, it is loaded on the same edge as the last byte leaves.
   tabp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_blk (head_blk),
      .qstat    (qstat),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

>>> hdl/tabp_checker.sv
// ----------------------------------------------------------------------------
// tabp_checker
// Port-level checks of the toy AES block pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tabp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tabp_pkg::BYTE_W-1:0] rsp_cipher_byte,
   input logic                        rsp_block_last,
   input logic                        rsp_message_last
);

   // A stalled response holds its byte and markers.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cipher_byte)
         && $stable(rsp_block_last) && $stable(rsp_message_last))
      else $error("response changed while stalled");

   // The message marker only comes with the last byte of a block.
   a_msg_in_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_last |-> rsp_block_last)
      else $error("message_last without block_last");

   // Coming out of reset nothing is pending and the queue has room.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

   // Just out of reset, with no request accepted while reset was high, no block is delivered yet.
   a_no_early_rsp: assert property (@(posedge clock)
      $past(reset) && !($past(req_valid) && $past(req_ready)) |=> !rsp_valid)
      else $error("response without a preceding request");

endmodule

bind toy_aes_block_pipeline_unit tabp_checker u_tabp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_cipher_byte  (rsp_ch.cipher_byte),
   .rsp_block_last   (rsp_ch.block_last),
   .rsp_message_last (rsp_ch.message_last)
);
